// File: hw/rtl/saeu_pkg.sv
// shared constants, types and fixed-point helpers for the surface anchoring energy unit
// no dependencies; imported by saeu_isqrt, saeu_div and surface_anchoring_energy_unit
package saeu_pkg;

  // vector components carry this many fraction bits
  localparam int FRAC   = 14;
  localparam int Q16_UP = 16 - FRAC;

  typedef logic signed [15:0] comp_t;

  // configuration register indexes
  localparam logic [2:0] CFG_W      = 3'd0;
  localparam logic [2:0] CFG_KIND   = 3'd1;
  localparam logic [2:0] CFG_LAMBDA = 3'd2;
  localparam logic [2:0] CFG_MU     = 3'd3;
  localparam logic [2:0] CFG_NU     = 3'd4;
  localparam logic [2:0] CFG_RHO    = 3'd5;
  localparam logic [2:0] CFG_SIGMA  = 3'd6;

  // neighbour kind codes
  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam logic [1:0] KIND_X4    = 2'd2;
  localparam logic [1:0] KIND_X6    = 2'd3;

  localparam logic signed [63:0] Q16_ONE   = 64'sd65536;
  localparam logic signed [63:0] Q16_HALF  = 64'sd32768;
  localparam logic signed [31:0] Q16_NINTH = 32'sd7282;

  // square root pipeline
  localparam int SQ_OUT_W  = 18;
  localparam int SQ_IN_W   = 2 * SQ_OUT_W;
  localparam int SQ_REM_W  = SQ_OUT_W + 3;
  localparam int SQ_PER_ST = 3;
  localparam int SQ_STAGES = SQ_OUT_W / SQ_PER_ST;

  // divider pipeline
  localparam int DV_Q_W    = 16;
  localparam int DV_DEN_W  = 18;
  localparam int DV_NUM_W  = 33;
  localparam int DV_PER_ST = 4;
  localparam int DV_STAGES = DV_Q_W / DV_PER_ST;

  // accept to result strobe
  localparam int SAEU_LAT = 37;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(x);
  endfunction

  // right shift rounding half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                              input int unsigned n);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] r;
    half = 64'd1 << (n - 1);
    mag  = x[63] ? 64'(-x) : 64'(x);
    r    = (mag + half) >> n;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(rshr(64'(a) * 64'(b), 16));
  endfunction

  function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

endpackage

// File: hw/rtl/surface_anchoring_energy_unit.sv
// surface anchoring energy, one lattice site per beat, fully pipelined
// depends on saeu_pkg, saeu_isqrt, saeu_div
// throughput: one beat per cycle while busy is low; two square root pipelines and three divider lanes
// each take a whole unit per beat, so nothing is shared between beats
// reset: synchronous; clears the valid chain, loads register defaults, busy high for one cycle
// results cannot be held off, so after that busy stays low until the next reset
module surface_anchoring_energy_unit import saeu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output logic               done,
  output logic signed [31:0] energy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // configuration
  logic signed [23:0] anchoring_strength;
  logic [1:0]         neighbour_kind;
  logic signed [23:0] coef_lambda, coef_mu, coef_nu, coef_rho, coef_sigma;
  logic signed [26:0] w_scaled;

  // valid chain, one bit per stage
  logic [1:SAEU_LAT] vld;

  // operand delay lines
  comp_t              ni_p [1:25][3];
  comp_t              s_p  [1:27][3];
  logic signed [18:0] ai_p [3:29];

  // front end: ai and its square root
  logic signed [31:0] pas [3];
  logic [SQ_IN_W-1:0] rad3;
  logic [SQ_OUT_W-1:0] root1;
  logic [15:0]        mod1;

  // second vector and its length
  logic signed [32:0] psm [3];
  logic signed [18:0] nj_p [11:19][3];
  logic [34:0]        sq [3];
  logic [SQ_IN_W-1:0] len2;
  logic [SQ_OUT_W-1:0] len;

  // normalization
  logic [DV_NUM_W-1:0] num [3];
  logic [DV_DEN_W-1:0] len20;
  logic                neg_p  [20:24][3];
  logic                zero_p [20:24];
  logic [DV_Q_W-1:0]   quot [3];
  logic signed [16:0]  njn [3];

  // dot and cross products
  logic signed [32:0] pjs [3], pjn [3], pca [3], pcb [3];
  logic signed [20:0] aj27, nij27, aj28, nij28, aj29, nij29;
  logic signed [19:0] cr [3];
  logic signed [35:0] pt [3];
  logic signed [23:0] trip29;

  // q16.16 tail
  logic signed [31:0] ai16, aj16, nij16, t4in;
  logic signed [31:0] m_nn, m_aa, m_jj, m_aj, t4_31, nij16_31;
  logic signed [31:0] pij, e1_32, t2a, t4_32;
  logic signed [31:0] rp, t3_33, t2_33, e1_33, t4_33;
  logic signed [31:0] rpl, e1_34, t2_34, t3_34, t4_34;
  logic signed [31:0] t1, t2_35, t3_35, t4_35;
  logic signed [31:0] inner;

  logic [63:0] chk_rad;

  assign cfg_ready = 1'b1;
  assign done      = vld[SAEU_LAT];
  assign mod1      = root1[15:0];

  // control: busy, valid chain, configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b1;
      vld                <= '0;
      anchoring_strength <= '0;
      neighbour_kind     <= KIND_PLAIN;
      coef_lambda        <= '0;
      coef_mu            <= '0;
      coef_nu            <= '0;
      coef_rho           <= '0;
      coef_sigma         <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {start && !busy, vld[1:SAEU_LAT-1]};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_W:      anchoring_strength <= cfg_data;
          CFG_KIND:   neighbour_kind     <= cfg_data[1:0];
          CFG_LAMBDA: coef_lambda        <= cfg_data;
          CFG_MU:     coef_mu            <= cfg_data;
          CFG_NU:     coef_nu            <= cfg_data;
          CFG_RHO:    coef_rho           <= cfg_data;
          CFG_SIGMA:  coef_sigma         <= cfg_data;
          default:    ;  // index past the register list is dropped
        endcase
      end
    end
  end

  // w scaled by neighbour kind; kind zero behaves as plain
  always_comb begin
    case (neighbour_kind)
      KIND_X4: w_scaled = 27'(anchoring_strength) <<< 2;
      KIND_X6: w_scaled = (27'(anchoring_strength) <<< 2) + (27'(anchoring_strength) <<< 1);
      default: w_scaled = 27'(anchoring_strength);
    endcase
  end

  // input delay lines
  always_ff @(posedge clk) begin
    ni_p[1] <= '{dir_x, dir_y, dir_z};
    s_p[1]  <= '{normal_x, normal_y, normal_z};
    for (int i = 2; i <= 25; i++) ni_p[i] <= ni_p[i-1];
    for (int i = 2; i <= 27; i++) s_p[i] <= s_p[i-1];
  end

  // stages 2-3: ai = ni.s and the square root operand
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) pas[k] <= 32'(64'(ni_p[1][k]) * 64'(s_p[1][k]));
    ai_p[3] <= 19'(rshr(64'(pas[0]) + 64'(pas[1]) + 64'(pas[2]), FRAC));
    for (int i = 4; i <= 29; i++) ai_p[i] <= ai_p[i-1];
    rad3    <= SQ_IN_W'(64'(rshr(64'(pas[0]) + 64'(pas[1]) + 64'(pas[2]), FRAC) < 0
                 ? -rshr(64'(pas[0]) + 64'(pas[1]) + 64'(pas[2]), FRAC)
                 : rshr(64'(pas[0]) + 64'(pas[1]) + 64'(pas[2]), FRAC)) << FRAC);
  end

  // stages 4-9: sqrt(|ai|)
  saeu_isqrt u_root_ai (
    .clk      (clk),
    .radicand (rad3),
    .root     (root1)
  );

  // stages 10-13: nj = ni - s*sqrt(|ai|), then its squared length
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      psm[k]     <= 33'(64'(s_p[9][k]) * 64'(mod1));
      nj_p[11][k] <= 19'(64'(ni_p[10][k]) - rshr(64'(psm[k]), FRAC));
      sq[k]      <= 35'(64'(nj_p[11][k]) * 64'(nj_p[11][k]));
    end
    for (int i = 12; i <= 19; i++) nj_p[i] <= nj_p[i-1];
    len2 <= SQ_IN_W'(64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]));
  end

  // stages 14-19: |nj|
  saeu_isqrt u_root_len (
    .clk      (clk),
    .radicand (len2),
    .root     (len)
  );

  // stage 20: rounded division operands, sign kept aside
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num[k]       <= DV_NUM_W'(((nj_p[19][k] < 0 ? -64'(nj_p[19][k]) : 64'(nj_p[19][k]))
                      << FRAC) + 64'(len >> 1));
      neg_p[20][k] <= nj_p[19][k][18];
    end
    len20      <= len;
    zero_p[20] <= (len == '0);
    for (int i = 21; i <= 24; i++) begin
      neg_p[i]  <= neg_p[i-1];
      zero_p[i] <= zero_p[i-1];
    end
  end

  // stages 21-24: one divider lane per component
  for (genvar k = 0; k < 3; k++) begin : g_lane
    saeu_div u_div (
      .clk  (clk),
      .num  (num[k]),
      .den  (len20),
      .quot (quot[k])
    );
  end

  // stage 25: signed unit vector; zero length means nj is all zero
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (zero_p[24]) begin
        njn[k] <= '0;
      end else if (neg_p[24][k]) begin
        njn[k] <= -$signed(17'(quot[k]));
      end else begin
        njn[k] <= $signed(17'(quot[k]));
      end
    end
  end

  // stages 26-29: aj, nij and the triple product
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pjs[k] <= 33'(64'(njn[k]) * 64'(s_p[25][k]));
      pjn[k] <= 33'(64'(ni_p[25][k]) * 64'(njn[k]));
    end
    pca[0] <= 33'(64'(ni_p[25][2]) * 64'(njn[1]));
    pcb[0] <= 33'(64'(ni_p[25][1]) * 64'(njn[2]));
    pca[1] <= 33'(64'(ni_p[25][0]) * 64'(njn[2]));
    pcb[1] <= 33'(64'(ni_p[25][2]) * 64'(njn[0]));
    pca[2] <= 33'(64'(ni_p[25][1]) * 64'(njn[0]));
    pcb[2] <= 33'(64'(ni_p[25][0]) * 64'(njn[1]));

    aj27  <= 21'(rshr(64'(pjs[0]) + 64'(pjs[1]) + 64'(pjs[2]), FRAC));
    nij27 <= 21'(rshr(64'(pjn[0]) + 64'(pjn[1]) + 64'(pjn[2]), FRAC));
    for (int k = 0; k < 3; k++) cr[k] <= 20'(rshr(64'(pca[k]) - 64'(pcb[k]), FRAC));

    for (int k = 0; k < 3; k++) pt[k] <= 36'(64'(cr[k]) * 64'(s_p[27][k]));
    aj28  <= aj27;
    nij28 <= nij27;

    trip29 <= 24'(rshr(64'(pt[0]) + 64'(pt[1]) + 64'(pt[2]), FRAC));
    aj29   <= aj28;
    nij29  <= nij28;
  end

  // stages 30-37: q16.16 combination, every product and sum saturates
  always_ff @(posedge clk) begin
    ai16  <= 32'(ai_p[29]) <<< Q16_UP;
    aj16  <= 32'(aj29) <<< Q16_UP;
    nij16 <= 32'(nij29) <<< Q16_UP;
    // chiral term follows the sign of nij
    t4in  <= (nij29 > 0) ? (32'(trip29) <<< Q16_UP) : sat32(-(64'(trip29) <<< Q16_UP));

    m_nn     <= mulq(nij16, nij16);
    m_aa     <= mulq(ai16, ai16);
    m_jj     <= mulq(aj16, aj16);
    m_aj     <= mulq(ai16, aj16);
    t4_31    <= mulq(32'(coef_sigma), t4in);
    nij16_31 <= nij16;

    pij   <= sat32(rshr(64'sd3 * 64'(m_nn), 1) - Q16_HALF);
    e1_32 <= sat32(rshr(64'sd3 * (64'(m_aa) + 64'(m_jj)), 1) - Q16_ONE);
    t2a   <= mulq(m_aj, nij16_31);
    t4_32 <= t4_31;

    rp    <= mulq(32'(coef_rho), pij);
    t3_33 <= mulq(32'(coef_nu), pij);
    t2_33 <= mulq(32'(coef_mu), t2a);
    e1_33 <= e1_32;
    t4_33 <= t4_32;

    rpl   <= addq(rp, 32'(coef_lambda));
    e1_34 <= e1_33;
    t2_34 <= t2_33;
    t3_34 <= t3_33;
    t4_34 <= t4_33;

    t1    <= mulq(e1_34, rpl);
    t2_35 <= t2_34;
    t3_35 <= t3_34;
    t4_35 <= t4_34;

    inner <= addq(addq(addq(addq(t1, t2_35), -Q16_NINTH), t3_35), t4_35);

    energy <= mulq(32'(w_scaled), inner);
  end

  // radicand seen by the first root, rebuilt for checking
  assign chk_rad = (ai_p[9] < 0 ? -64'(ai_p[9]) : 64'(ai_p[9])) << FRAC;

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##SAEU_LAT done)
    else $error("accepted beat did not produce a result on time");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, SAEU_LAT))
    else $error("result strobe without a matching accepted beat");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[9] |-> ((64'(mod1) * 64'(mod1) <= chk_rad) &&
                ((64'(mod1) + 64'd1) * (64'(mod1) + 64'd1) > chk_rad)))
    else $error("square root of |ai| is not the floor root");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    vld[25] |-> ((njn[0] <= 17'sd16384) && (njn[0] >= -17'sd16384) &&
                 (njn[1] <= 17'sd16384) && (njn[1] >= -17'sd16384) &&
                 (njn[2] <= 17'sd16384) && (njn[2] >= -17'sd16384)))
    else $error("normalized component exceeds one");

endmodule

// File: hw/rtl/saeu_isqrt.sv
// pipelined floor square root, a few result bits per stage
// depends on saeu_pkg
module saeu_isqrt import saeu_pkg::*; (
  input  logic                clk,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0]  rad_q  [1:SQ_STAGES-1];
  logic [SQ_REM_W-1:0] rem_q  [1:SQ_STAGES-1];
  logic [SQ_OUT_W-1:0] root_q [1:SQ_STAGES];

  for (genvar st = 0; st < SQ_STAGES; st++) begin : g_st
    logic [SQ_IN_W-1:0]  rad_in, rad_c;
    logic [SQ_REM_W-1:0] rem_in, rem_c, trial;
    logic [SQ_OUT_W-1:0] root_in, root_c;

    if (st == 0) begin : g_head
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign rad_in  = rad_q[st];
      assign rem_in  = rem_q[st];
      assign root_in = root_q[st];
    end

    always_comb begin
      rad_c  = rad_in;
      rem_c  = rem_in;
      root_c = root_in;
      trial  = '0;
      for (int j = 0; j < SQ_PER_ST; j++) begin
        rem_c = {rem_c[SQ_REM_W-3:0], rad_c[SQ_IN_W-1 -: 2]};
        trial = SQ_REM_W'({root_c, 2'b01});
        if (rem_c >= trial) begin
          rem_c  = rem_c - trial;
          root_c = {root_c[SQ_OUT_W-2:0], 1'b1};
        end else begin
          root_c = {root_c[SQ_OUT_W-2:0], 1'b0};
        end
        rad_c = rad_c << 2;
      end
    end

    if (st < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rad_q[st+1] <= rad_c;
        rem_q[st+1] <= rem_c;
      end
    end

    always_ff @(posedge clk) begin
      root_q[st+1] <= root_c;
    end
  end

  assign root = root_q[SQ_STAGES];

endmodule

// File: hw/rtl/saeu_div.sv
// pipelined restoring divider, unsigned, a few quotient bits per stage
// depends on saeu_pkg
module saeu_div import saeu_pkg::*; (
  input  logic                clk,
  input  logic [DV_NUM_W-1:0] num,
  input  logic [DV_DEN_W-1:0] den,
  output logic [DV_Q_W-1:0]   quot
);

  logic [DV_DEN_W-1:0] rem_q [1:DV_STAGES-1];
  logic [DV_Q_W-1:0]   low_q [1:DV_STAGES-1];
  logic [DV_DEN_W-1:0] den_q [1:DV_STAGES-1];
  logic [DV_Q_W-1:0]   q_q   [1:DV_STAGES];

  for (genvar st = 0; st < DV_STAGES; st++) begin : g_st
    logic [DV_DEN_W-1:0] rem_in, rem_c, den_in;
    logic [DV_Q_W-1:0]   low_in, low_c, q_in, q_c;
    logic [DV_DEN_W:0]   part;
    logic                ge;

    if (st == 0) begin : g_head
      // quotient fits, so the upper numerator bits sit below the divisor
      assign rem_in = DV_DEN_W'(num[DV_NUM_W-1:DV_Q_W]);
      assign low_in = num[DV_Q_W-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_body
      assign rem_in = rem_q[st];
      assign low_in = low_q[st];
      assign den_in = den_q[st];
      assign q_in   = q_q[st];
    end

    always_comb begin
      rem_c = rem_in;
      low_c = low_in;
      q_c   = q_in;
      part  = '0;
      ge    = 1'b0;
      for (int j = 0; j < DV_PER_ST; j++) begin
        part  = {rem_c, low_c[DV_Q_W-1]};
        ge    = (part >= {1'b0, den_in});
        rem_c = ge ? DV_DEN_W'(part - {1'b0, den_in}) : part[DV_DEN_W-1:0];
        q_c   = {q_c[DV_Q_W-2:0], ge};
        low_c = low_c << 1;
      end
    end

    if (st < DV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[st+1] <= rem_c;
        low_q[st+1] <= low_c;
        den_q[st+1] <= den_in;
      end
    end

    always_ff @(posedge clk) begin
      q_q[st+1] <= q_c;
    end
  end

  assign quot = q_q[DV_STAGES];

endmodule
